/* src/bifl_pkg.sv */
package bifl_pkg;

   localparam int NUM_BUFFERS = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int STATUS_W    = 2;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NOT_BUSY = 2'd2
   } status_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   // Write request into the free stack memory.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } stack_wr_type;

   // Read request into the free stack memory.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } stack_rd_type;

endpackage

/* src/bifl_if.sv */
interface bifl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [bifl_pkg::IDX_W-1:0]   release_index;

   modport source (output valid, output op, output release_index, input ready);
   modport sink   (input valid, input op, input release_index, output ready);
endinterface

interface bifl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bifl_pkg::IDX_W-1:0]    granted_index;
   logic [bifl_pkg::STATUS_W-1:0] status;
   logic [bifl_pkg::CNT_W-1:0]    free_count;

   modport source (output valid, output granted_index, output status, output free_count,
                   input ready);
   modport sink   (input valid, input granted_index, input status, input free_count,
                   output ready);
endinterface

/* src/bifl_stack.sv */
module bifl_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  bifl_pkg::stack_rd_type        rd_req,
   input  bifl_pkg::stack_wr_type        wr_req,
   output logic [bifl_pkg::IDX_W-1:0]    rd_data
);

   logic [bifl_pkg::IDX_W-1:0]       stack_mem_ff [bifl_pkg::NUM_BUFFERS];
   logic [bifl_pkg::NUM_BUFFERS-1:0] written_ff;
   logic [bifl_pkg::NUM_BUFFERS-1:0] written_in;
   logic [bifl_pkg::IDX_W-1:0]       rd_q_ff;
   logic [bifl_pkg::IDX_W-1:0]       rd_addr_ff;
   logic                             rd_hit_ff;

   // Synchronous memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         stack_mem_ff[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_q_ff    <= stack_mem_ff[rd_req.addr];
         rd_addr_ff <= rd_req.addr;
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_req.en) begin
         written_in[wr_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_hit_ff  <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (rd_req.en) begin
            rd_hit_ff <= written_ff[rd_req.addr];
         end
      end
   end

   // An entry never written holds its reset value, which puts slot 0 on top.
   assign rd_data = rd_hit_ff ? rd_q_ff
                              : bifl_pkg::IDX_W'(bifl_pkg::NUM_BUFFERS - 1) - rd_addr_ff;

endmodule

/* src/buffer_index_free_list_top.sv */
// Buffer slot allocator built on a last-in-first-out stack of free slot numbers.
// The req_chan channel carries one item per request: op selects acquire or
// release, release_index names the slot handed back on a release. The rsp_chan
// channel returns exactly one item per request with the granted slot, a status
// (ok, pool empty, release of a slot that is not busy) and the free slot count
// after the request. Both channels use a valid/ready handshake.
// An accepted request moves the block from IDLE to EXEC, and its response is
// registered when EXEC completes. The free stack lives in a memory with a
// registered read; each request reads it, then updates it, so the block takes
// no new request until the last one has updated the stack and it is in IDLE.
// A response waits in an output register; the next request is accepted while it
// waits, and that request's update holds until the output register is taken.
// Reset (synchronous, active high) frees every slot with slot 0 on top of the
// stack. The memory needs no clearing pass: a per-entry written bit makes
// untouched entries read as their reset contents, so requests are accepted in
// the first cycle after reset.
module buffer_index_free_list_top (
   input  logic        clock,
   input  logic        reset,
   bifl_req_if.sink    req_chan,
   bifl_rsp_if.source  rsp_chan
);

   bifl_pkg::state_type              state_ff, state_in;
   logic                             op_ff;
   logic [bifl_pkg::IDX_W-1:0]       idx_ff;
   logic [bifl_pkg::CNT_W-1:0]       depth_ff, depth_in;
   logic [bifl_pkg::NUM_BUFFERS-1:0] busy_ff, busy_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bifl_pkg::IDX_W-1:0]       granted_ff, granted_in;
   bifl_pkg::status_type             status_ff, status_in;
   logic [bifl_pkg::CNT_W-1:0]       count_ff, count_in;

   bifl_pkg::stack_rd_type           rd_req;
   bifl_pkg::stack_wr_type           wr_req;
   logic [bifl_pkg::IDX_W-1:0]       top_slot;
   logic                             accept;
   logic                             out_free;

   bifl_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rd_data (top_slot)
   );

   assign req_chan.ready = (state_ff == bifl_pkg::STATE_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // The top entry is read on every accepted item; a release ignores it.
   always_comb begin
      rd_req.en   = accept;
      rd_req.addr = depth_ff[bifl_pkg::IDX_W-1:0] - bifl_pkg::IDX_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      granted_in   = granted_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      wr_req.en    = 1'b0;
      wr_req.addr  = depth_ff[bifl_pkg::IDX_W-1:0];
      wr_req.data  = idx_ff;

      case (state_ff)
         bifl_pkg::STATE_IDLE: begin
            if (accept) begin
               state_in = bifl_pkg::STATE_EXEC;
            end
         end
         bifl_pkg::STATE_EXEC: begin
            // Read-modify-write of the stack once the output register has room.
            if (out_free) begin
               granted_in = '0;
               status_in  = bifl_pkg::STATUS_OK;
               if (op_ff == bifl_pkg::OP_ACQUIRE) begin
                  if (depth_ff == '0) begin
                     status_in = bifl_pkg::STATUS_EMPTY;
                  end else begin
                     depth_in          = depth_ff - bifl_pkg::CNT_W'(1);
                     busy_in[top_slot] = 1'b1;
                     granted_in        = top_slot;
                  end
               end else begin
                  if (!busy_ff[idx_ff]) begin
                     status_in = bifl_pkg::STATUS_NOT_BUSY;
                  end else begin
                     busy_in[idx_ff] = 1'b0;
                     if (depth_ff < bifl_pkg::CNT_W'(bifl_pkg::NUM_BUFFERS)) begin
                        wr_req.en = 1'b1;
                        depth_in  = depth_ff + bifl_pkg::CNT_W'(1);
                     end
                  end
               end
               count_in     = depth_in;
               rsp_valid_in = 1'b1;
               state_in     = bifl_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = bifl_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bifl_pkg::STATE_IDLE;
         depth_ff     <= bifl_pkg::CNT_W'(bifl_pkg::NUM_BUFFERS);
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.op;
         idx_ff <= req_chan.release_index;
      end
      granted_ff <= granted_in;
      status_ff  <= status_in;
      count_ff   <= count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.granted_index = granted_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.free_count    = count_ff;

endmodule
